// ===== sv/scalar_kalman_filter_assert.svh =====
// Assertion macros for the scalar Kalman filter.
// Used inside modules that have clk and arst_n in scope; no other dependencies.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/skf_pkg.sv =====
// Shared constants and types for the scalar Kalman filter.
// No dependencies; used by skf_div, skf_mul and scalar_kalman_filter.
`timescale 1ns / 1ps

package skf_pkg;

	localparam int CHANNELS  = 3;
	localparam int FRAC_BITS = 16;

	localparam int CH_W     = 2;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEAS_W   = 16;
	localparam int DATA_W   = 32;
	localparam int GAIN_W   = 17;
	localparam int DEN_W    = DATA_W + 1;
	localparam int PROD_W   = GAIN_W + 1 + DEN_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = DATA_W'(655);
	localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = DATA_W'(65536);

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== sv/scalar_kalman_filter.sv =====
// Scalar Kalman filter, one estimate and covariance per channel, one shared divider and multiplier.
// An out-of-range channel skips the divider and multiplier and goes straight to the result.
// Items are handled one at a time; the 17-step gain divider takes most of the time per item.
// The input is not ready until the item's result sits in the output register.
// Reset (arst_n low, asynchronous): estimates and covariances zero, Q = 655, R = 65536.
// Depends on skf_pkg, skf_div, skf_mul and scalar_kalman_filter_assert.svh.
`timescale 1ns / 1ps

module scalar_kalman_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [skf_pkg::DATA_W-1:0]        cfg_wdata,
	// input item stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,  // [1:0] channel, [17:2] measurement
	// result item stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [55:0]                       m_axis_tdata   // [1:0] out_channel, [33:2] estimate,
	                                                         // [50:34] gain
);

	localparam int DW = skf_pkg::DATA_W;
	localparam int GW = skf_pkg::GAIN_W;
	localparam int M_W = 48;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
	localparam logic [2:0] S_PRIOR = 3'd1;  // prior covariance, scaled sample
	localparam logic [2:0] S_DENOM = 3'd2;  // denominator, innovation, start divider
	localparam logic [2:0] S_DIV   = 3'd3;  // wait for gain
	localparam logic [2:0] S_MUL_E = 3'd4;  // gain * innovation into the multiplier
	localparam logic [2:0] S_MUL_C = 3'd5;  // (1 - gain) * prior, take new estimate
	localparam logic [2:0] S_WB    = 3'd6;  // write back channel state
	localparam logic [2:0] S_OUT   = 3'd7;  // hand result to the output register

	logic [2:0] state_q;

	// Configuration registers.
	logic [DW-1:0] process_noise_q;
	logic [DW-1:0] measure_noise_q;

	// Per-channel state.
	logic signed [DW-1:0] est_q [skf_pkg::CHANNELS];
	logic        [DW-1:0] cov_q [skf_pkg::CHANNELS];

	// Item working registers.
	logic [skf_pkg::CH_W-1:0]          channel_q;
	logic signed [skf_pkg::MEAS_W-1:0] meas_q;
	logic signed [DW-1:0]              m_q;
	logic signed [DW-1:0]              cur_est_q;
	logic [DW-1:0]                     prior_q;
	logic signed [skf_pkg::DEN_W-1:0]  innov_q;
	logic [GW-1:0]                     gain_q;
	logic signed [DW-1:0]              newest_q;

	// Output register.
	logic                              out_valid_q;
	logic [skf_pkg::CH_W-1:0]          out_ch_q;
	logic signed [DW-1:0]              out_est_q;
	logic [GW-1:0]                     out_gain_q;

	logic [skf_pkg::CH_IDX_W-1:0]      ch_idx;
	logic                              ch_ok;
	logic [DW:0]                       prior_sum;
	logic [skf_pkg::DEN_W-1:0]         denom;
	logic signed [M_W-1:0]             m_wide;
	logic signed [DW-1:0]              m_sat;
	logic                              accept;
	logic                              out_free;

	logic                              div_start;
	skf_pkg::div_status_t              div_st;
	logic [GW-1:0]                     div_quot;

	logic [GW-1:0]                     mul_a;
	logic signed [skf_pkg::DEN_W-1:0]  mul_b;
	logic signed [skf_pkg::PROD_W-1:0] mul_p;

	logic signed [DW+2:0]              delta;
	logic signed [DW+3:0]              est_sum;
	logic signed [DW-1:0]              est_sat;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign ch_idx = channel_q[skf_pkg::CH_IDX_W-1:0];
	assign ch_ok  = (channel_q < skf_pkg::CH_W'(skf_pkg::CHANNELS));

	// Prior covariance P + Q, saturated at all ones.
	assign prior_sum = {1'b0, cov_q[ch_idx]} + {1'b0, process_noise_q};

	// Scaled sample, saturated to the signed 32-bit range.
	assign m_wide = M_W'(meas_q) <<< skf_pkg::FRAC_BITS;
	always_comb begin
		if (m_wide > M_W'(64'sh7FFFFFFF)) begin
			m_sat = {1'b0, {(DW-1){1'b1}}};
		end else if (m_wide < -M_W'(64'sh80000000)) begin
			m_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			m_sat = m_wide[DW-1:0];
		end
	end

	// Denominator P' + R, kept exact in 33 bits.
	assign denom     = {1'b0, prior_q} + {1'b0, measure_noise_q};
	assign div_start = (state_q == S_DENOM);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (prior_q),
		.denom  (denom),
		.status (div_st),
		.quot   (div_quot)
	);

	// The one multiplier serves both products: estimate update, then covariance.
	always_comb begin
		if (state_q == S_MUL_C) begin
			mul_a = skf_pkg::GAIN_ONE - gain_q;
			mul_b = signed'({1'b0, prior_q});
		end else begin
			mul_a = gain_q;
			mul_b = innov_q;
		end
	end

	skf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Floor of K * innovation / 2^16 is an arithmetic shift; add and saturate.
	assign delta   = mul_p[skf_pkg::PROD_W-1:16];
	assign est_sum = (DW+4)'(cur_est_q) + (DW+4)'(delta);
	always_comb begin
		if (est_sum > (DW+4)'(64'sh7FFFFFFF)) begin
			est_sat = {1'b0, {(DW-1){1'b1}}};
		end else if (est_sum < -(DW+4)'(64'sh80000000)) begin
			est_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			est_sat = est_sum[DW-1:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_PRIOR;
				end
				S_PRIOR: begin
					// An out-of-range channel skips straight to the result.
					state_q <= ch_ok ? S_DENOM : S_OUT;
				end
				S_DENOM: state_q <= S_DIV;
				S_DIV: begin
					if (div_st.done) state_q <= S_MUL_E;
				end
				S_MUL_E: state_q <= S_MUL_C;
				S_MUL_C: state_q <= S_WB;
				S_WB:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			channel_q <= s_axis_tdata[1:0];
			meas_q    <= signed'(s_axis_tdata[17:2]);
		end
		if (state_q == S_PRIOR) begin
			m_q       <= m_sat;
			cur_est_q <= est_q[ch_idx];
			prior_q   <= prior_sum[DW] ? {DW{1'b1}} : prior_sum[DW-1:0];
			if (!ch_ok) begin
				gain_q   <= '0;
				newest_q <= '0;
			end
		end
		if (state_q == S_DENOM) begin
			innov_q <= skf_pkg::DEN_W'(m_q) - skf_pkg::DEN_W'(cur_est_q);
		end
		if (state_q == S_DIV && div_st.done) begin
			gain_q <= div_quot;
		end
		if (state_q == S_MUL_C) begin
			newest_q <= est_sat;
		end
	end

	// Channel state: cleared by reset, written once per in-range item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < skf_pkg::CHANNELS; i++) begin
				est_q[i] <= '0;
				cov_q[i] <= '0;
			end
		end else if (state_q == S_WB) begin
			est_q[ch_idx] <= newest_q;
			// (1 - K) * P' / 2^16 never exceeds P', so the low word is exact.
			cov_q[ch_idx] <= mul_p[DW+15:16];
		end
	end

	// Configuration writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= skf_pkg::PROCESS_NOISE_RST;
			measure_noise_q <= skf_pkg::MEASURE_NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				skf_pkg::REG_PROCESS_NOISE: process_noise_q <= cfg_wdata;
				skf_pkg::REG_MEASURE_NOISE: measure_noise_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Output register: hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_ch_q   <= channel_q;
			out_est_q  <= newest_q;
			out_gain_q <= gain_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_gain_q, out_est_q, out_ch_q};

	`include "scalar_kalman_filter_assert.svh"

	`SKF_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready,
		"input still ready the cycle after an item was accepted")
	`SKF_ASSERT_NOW(a_div_done_in_wait, div_st.done, state_q == S_DIV,
		"gain divider finished outside the wait state")
	`SKF_ASSERT_NOW(a_gain_range, m_axis_tvalid, out_gain_q <= skf_pkg::GAIN_ONE,
		"result gain above one")
	`SKF_ASSERT_NOW(a_bad_channel_zero,
		m_axis_tvalid && (out_ch_q >= skf_pkg::CH_W'(skf_pkg::CHANNELS)),
		(out_est_q == '0) && (out_gain_q == '0),
		"out-of-range channel gave a nonzero result")

endmodule

// ===== sv/skf_div.sv =====
// Iterative restoring divider for the Kalman gain: floor(prior * 2^16 / denom).
// One quotient bit per cycle, 17 bits in all. Depends on skf_pkg.
`timescale 1ns / 1ps

module skf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [skf_pkg::DATA_W-1:0]        numer,
	input  logic [skf_pkg::DEN_W-1:0]         denom,
	output skf_pkg::div_status_t              status,
	output logic [skf_pkg::GAIN_W-1:0]        quot
);

	localparam int CNT_W = $clog2(skf_pkg::GAIN_W + 1);

	logic [skf_pkg::DEN_W-1:0]  rem_q;
	logic [skf_pkg::DEN_W-1:0]  den_q;
	logic [skf_pkg::GAIN_W-1:0] quot_q;
	logic                       bit_q;
	logic                       zero_q;
	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;

	logic [skf_pkg::DEN_W:0]    trial;
	logic [skf_pkg::DEN_W:0]    diff;
	logic                       ge;

	// Shift in one numerator bit, subtract when the divisor fits.
	assign trial = {rem_q, bit_q};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(skf_pkg::GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Start from numer >> 1 with its low bit pending, so all 17 steps look alike.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, numer[skf_pkg::DATA_W-1:1]};
			bit_q  <= numer[0];
			den_q  <= denom;
			quot_q <= '0;
			zero_q <= (denom == '0);
		end else if (busy_q) begin
			rem_q  <= ge ? diff[skf_pkg::DEN_W-1:0] : trial[skf_pkg::DEN_W-1:0];
			bit_q  <= 1'b0;
			quot_q <= {quot_q[skf_pkg::GAIN_W-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	// A zero denominator gives gain zero.
	assign quot = zero_q ? '0 : quot_q;

endmodule

// ===== sv/skf_mul.sv =====
// Shared registered multiplier: unsigned 17-bit factor times signed 33-bit factor.
// Product is registered and available in the cycle after the operands. Depends on skf_pkg.
`timescale 1ns / 1ps

module skf_mul (
	input  logic                                clk,
	input  logic [skf_pkg::GAIN_W-1:0]          a,
	input  logic signed [skf_pkg::DEN_W-1:0]    b,
	output logic signed [skf_pkg::PROD_W-1:0]   p_q
);

	logic signed [skf_pkg::GAIN_W:0] a_s;

	assign a_s = signed'({1'b0, a});

	// Widen both factors first so the full product is kept.
	always_ff @(posedge clk) begin
		p_q <= skf_pkg::PROD_W'(a_s) * skf_pkg::PROD_W'(b);
	end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for scalar_kalman_filter: streams measurement items through
// the block and checks every result item against a built-in fixed-point filter predictor.
// Depends on skf_pkg and the scalar_kalman_filter RTL; needs no other files.
`timescale 1ns / 1ps

module tb_top;

	// one result item as the block packs it
	typedef struct packed {
		logic [skf_pkg::CH_W-1:0]          channel;
		logic signed [skf_pkg::DATA_W-1:0] estimate;
		logic [skf_pkg::GAIN_W-1:0]        gain;
	} kalman_result_t;

	localparam longint U32_MAX    = 64'h0000_0000_FFFF_FFFF;
	localparam longint S32_MAX    = 64'sd2147483647;
	localparam longint S32_MIN    = -64'sd2147483648;
	localparam longint UNITY_GAIN = 64'sd65536;
	localparam int     HOLD_CYCLES = 400;
	localparam int     HOLD_AFTER  = 120;
	localparam int     DRAIN_CYCLES = 30;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [skf_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [skf_pkg::DATA_W-1:0]    cfg_wdata = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [23:0]                   s_axis_tdata = '0;   // [1:0] channel, [17:2] measurement
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [55:0]                   m_axis_tdata;        // [1:0] out_channel, [33:2] estimate,
	                                                    // [50:34] gain

	// predictor copy of the filter state and the noise registers
	logic signed [skf_pkg::DATA_W-1:0] est_state [skf_pkg::CHANNELS];
	logic [skf_pkg::DATA_W-1:0]        cov_state [skf_pkg::CHANNELS];
	logic [skf_pkg::DATA_W-1:0]        q_model = skf_pkg::PROCESS_NOISE_RST;
	logic [skf_pkg::DATA_W-1:0]        r_model = skf_pkg::MEASURE_NOISE_RST;

	logic [23:0]    sample_queue [$];
	kalman_result_t expected_updates [$];

	int mismatch_count = 0;
	int results_seen = 0;
	int tx_idle_rate = 0;
	int rx_idle_rate = 0;
	int tx_gap_left = 0;
	int rx_gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	scalar_kalman_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < skf_pkg::CHANNELS; i++) begin
			est_state[i] = '0;
			cov_state[i] = '0;
		end
	end

	function automatic longint clamp_s32(input longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	// Advance the predicted filter by one measurement and return the result item it gives.
	function automatic kalman_result_t kalman_step(input logic [skf_pkg::CH_W-1:0] ch,
			input logic signed [skf_pkg::MEAS_W-1:0] sample);
		kalman_result_t res;
		longint meas, est, prior, denom, k, innov, upd, cov;
		res.channel = ch;
		res.estimate = '0;
		res.gain = '0;
		// an out-of-range channel leaves the state alone and reports zeros
		if (ch >= skf_pkg::CHANNELS)
			return res;
		meas = clamp_s32(longint'(sample) * (longint'(1) << skf_pkg::FRAC_BITS));
		est = longint'(est_state[ch]);
		// prior covariance saturates at the unsigned 32-bit top
		prior = longint'({32'b0, cov_state[ch]}) + longint'({32'b0, q_model});
		if (prior > U32_MAX)
			prior = U32_MAX;
		// denominator is kept exact in 33 bits; zero denominator means zero gain
		denom = prior + longint'({32'b0, r_model});
		k = (denom == 0) ? 0 : (prior * UNITY_GAIN) / denom;
		innov = meas - est;
		// arithmetic shift floors toward minus infinity
		upd = clamp_s32(est + ((k * innov) >>> 16));
		cov = ((UNITY_GAIN - k) * prior) >>> 16;
		est_state[ch] = skf_pkg::DATA_W'(upd);
		cov_state[ch] = skf_pkg::DATA_W'(cov);
		res.estimate = skf_pkg::DATA_W'(upd);
		res.gain = skf_pkg::GAIN_W'(k);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Write one register while the block is idle; track it in the predictor as well.
	task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
			input logic [skf_pkg::DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		if (idx == skf_pkg::REG_PROCESS_NOISE)
			q_model = value;
		else if (idx == skf_pkg::REG_MEASURE_NOISE)
			r_model = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_noise(input logic [skf_pkg::DATA_W-1:0] q,
			input logic [skf_pkg::DATA_W-1:0] r);
		write_reg(skf_pkg::REG_PROCESS_NOISE, q);
		write_reg(skf_pkg::REG_MEASURE_NOISE, r);
		@(negedge clk);
	endtask

	task automatic queue_sample(input int ch, input int meas);
		sample_queue.push_back({6'b0, 16'(meas), 2'(ch)});
	endtask

	function automatic logic [skf_pkg::MEAS_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000 + 16'($urandom_range(0, 15));
			1: return 16'h7FFF - 16'($urandom_range(0, 15));
			2, 3: return 16'($urandom_range(0, 200)) - 16'd100;
			default: return 16'($urandom);
		endcase
	endfunction

	// Queue well-formed channel traffic with a sprinkle of out-of-range channels.
	task automatic queue_random(input int count);
		int ch;
		for (int i = 0; i < count; i++) begin
			ch = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, skf_pkg::CHANNELS - 1);
			queue_sample(ch, int'(pick_sample()));
		end
	endtask

	// Hold until every queued item is accepted and every result has come back, then let
	// the pipeline settle. Check at the falling edge so the driver's updates from the
	// rising edge are already in place.
	task automatic wait_idle();
		@(negedge clk);
		while (sample_queue.size() != 0 || s_axis_tvalid || expected_updates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: offer queued items, hold an offered item until accepted, idle in bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			// the item on the bus was just accepted: predict its result now
			if (s_axis_tvalid)
				expected_updates.push_back(kalman_step(s_axis_tdata[1:0], s_axis_tdata[17:2]));
			if (tx_gap_left != 0) begin
				tx_gap_left <= tx_gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (tx_idle_rate != 0 && $urandom_range(0, 99) < tx_idle_rate) begin
				tx_gap_left <= $urandom_range(0, 4);
				s_axis_tvalid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= sample_queue.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, once: the block fills up and must stall its input.
	always @(posedge clk) begin
		if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver ready: drop it during the hold-off and in random short bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap_left != 0) begin
			rx_gap_left <= rx_gap_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_rate != 0 && $urandom_range(0, 99) < rx_idle_rate) begin
			rx_gap_left <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		kalman_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (expected_updates.size() == 0) begin
				report_mismatch($sformatf("result item %h with nothing expected", m_axis_tdata));
			end else begin
				want = expected_updates.pop_front();
				if (m_axis_tdata[1:0] !== want.channel)
					report_mismatch($sformatf("out_channel got %0d want %0d",
						m_axis_tdata[1:0], want.channel));
				if (m_axis_tdata[33:2] !== want.estimate)
					report_mismatch($sformatf("ch %0d estimate got %h want %h",
						want.channel, m_axis_tdata[33:2], want.estimate));
				if (m_axis_tdata[50:34] !== want.gain)
					report_mismatch($sformatf("ch %0d gain got %h want %h",
						want.channel, m_axis_tdata[50:34], want.gain));
			end
		end
	end

	// Main sequence: reset, directed phases, random phases, then the verdict.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// reset noise values: full-scale samples on every channel, out-of-range channel too
		queue_sample(0, 32767);
		queue_sample(1, -32768);
		queue_sample(2, 0);
		queue_sample(3, 32767);
		queue_sample(3, -32768);
		queue_sample(0, -32768);
		queue_sample(1, 32767);
		queue_sample(2, -1);
		queue_sample(0, 1);
		wait_idle();

		// Q = R = 0: the first step per channel takes full gain and clears the covariance,
		// the second hits the zero denominator and must leave the estimate alone
		set_noise('0, '0);
		queue_sample(0, 100);
		queue_sample(0, -5);
		queue_sample(1, -32768);
		queue_sample(1, 32767);
		queue_sample(2, 32767);
		queue_sample(2, -32768);
		queue_sample(3, 0);
		wait_idle();

		// both noise registers at the top: saturated prior, gain near one half
		set_noise('1, '1);
		queue_sample(0, 32767);
		queue_sample(1, -32768);
		queue_sample(2, 12345);
		queue_sample(0, -32768);
		wait_idle();

		// saturated prior with no measurement noise: unity gain
		set_noise('1, '0);
		queue_sample(0, -32768);
		queue_sample(1, 32767);
		queue_sample(2, -7);
		wait_idle();

		// random phases, each under its own noise setting and idling mix
		tx_idle_rate = 15;
		rx_idle_rate = 15;
		set_noise(skf_pkg::PROCESS_NOISE_RST, skf_pkg::MEASURE_NOISE_RST);
		queue_random(100);
		wait_idle();

		tx_idle_rate = 30;
		rx_idle_rate = 0;
		set_noise($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
		queue_random(100);
		wait_idle();

		tx_idle_rate = 0;
		rx_idle_rate = 30;
		set_noise($urandom, $urandom);
		queue_random(100);
		wait_idle();

		tx_idle_rate = 10;
		rx_idle_rate = 20;
		set_noise('0, $urandom);
		queue_random(100);
		wait_idle();

		tx_idle_rate = 20;
		rx_idle_rate = 10;
		set_noise($urandom, '0);
		queue_random(100);
		wait_idle();

		tx_idle_rate = 15;
		rx_idle_rate = 15;
		set_noise('1, $urandom_range(0, 1 << 18));
		queue_random(100);
		wait_idle();

		// closing stretch: no idling on either side
		tx_idle_rate = 0;
		rx_idle_rate = 0;
		set_noise($urandom, $urandom);
		queue_random(100);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("scalar_kalman_filter verification clean");
		end else begin
			$display("scalar_kalman_filter verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("scalar_kalman_filter verification failed");
		$finish;
	end

endmodule
